// ----- rtl/btrq_pkg.sv -----
// Shared types and constants for the beacon table range query block.
// No dependencies; every other file of the block except btrq_ram imports this package.
`default_nettype none

package btrq_pkg;

  localparam int unsigned COORD_W = 20;
  localparam int unsigned RAD_W   = 19;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned CMP_W   = 7;   // wide enough for any id and for the count itself
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_RETURNED = 2'd0;
  localparam logic [1:0] ST_ADDED    = 2'd1;
  localparam logic [1:0] ST_NOMATCH  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [RAD_W-1:0]          radius;
    logic [ID_W-1:0]           wanted_id;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] beacon_x;
    logic signed [COORD_W-1:0] beacon_y;
    logic [ID_W-1:0]           beacon_id;
    logic [1:0]                status;
    logic                      last;
  } out_item_t;

  typedef enum logic [1:0] {
    K_ADD,
    K_GET,
    K_QUERY,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [RAD_W-1:0]          radius;
    logic [ID_W-1:0]           wanted_id;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GET,
    BK_PREP,
    BK_SCAN,
    BK_DRAIN
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/btrq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module btrq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/btrq_front.sv -----
// Front end: accepts command beats, decodes the operation and queues them.
// Depends on btrq_pkg.
`default_nettype none

module btrq_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire btrq_pkg::in_item_t  item_i,
  input  wire logic                pop_i,
  output logic                     cmd_valid_o,
  output btrq_pkg::cmd_t           cmd_o
);
  import btrq_pkg::*;

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;
  cmd_t              cmd_new;

  // Decode the operation code; the unused code becomes a no-op.
  always_comb begin
    cmd_new.point_x   = item_i.point_x;
    cmd_new.point_y   = item_i.point_y;
    cmd_new.radius    = item_i.radius;
    cmd_new.wanted_id = item_i.wanted_id;
    case (item_i.operation)
      OP_ADD:   cmd_new.kind = K_ADD;
      OP_GET:   cmd_new.kind = K_GET;
      OP_QUERY: cmd_new.kind = K_QUERY;
      default:  cmd_new.kind = K_NOP;
    endcase
  end

  assign busy_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/btrq_back.sv -----
// Back end: owns the beacon table, runs add/get and the pipelined range scan.
// Depends on btrq_pkg and btrq_ram.
`default_nettype none

module btrq_back #(
  parameter int unsigned MAX_BEACONS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire btrq_pkg::cmd_t   cmd_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  output btrq_pkg::out_item_t   res_o
);
  import btrq_pkg::*;

  localparam int unsigned AW   = (MAX_BEACONS > 1) ? $clog2(MAX_BEACONS) : 1;
  localparam int unsigned CW   = $clog2(MAX_BEACONS + 1);
  localparam int unsigned DW   = 2 * COORD_W;
  localparam int unsigned DX_W = COORD_W + 1;
  localparam int unsigned SQ_W = 2 * COORD_W + 1;
  localparam int unsigned D2_W = SQ_W + 1;
  localparam int unsigned R2_W = 2 * RAD_W;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_BEACONS);

  back_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [AW-1:0] gid_q, gid_d;
  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic [RAD_W-1:0] rad_q;
  logic [R2_W-1:0]  r2_q;
  logic             load_query;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic          issue;

  // scan pipeline: read -> subtract -> square -> sum and compare
  logic rd_v_q, sub_v_q, mul_v_q, hit_v_q;
  logic [AW-1:0] rd_idx_q, sub_idx_q, mul_idx_q, hit_idx_q;
  logic signed [COORD_W-1:0] sub_x_q, sub_y_q, mul_x_q, mul_y_q, hit_x_q, hit_y_q;
  logic signed [DX_W-1:0] dx_q, dy_q, dx_d, dy_d;
  logic signed [2*DX_W-1:0] px_prod, py_prod;
  logic [SQ_W-1:0] sqx_q, sqy_q;
  logic [D2_W-1:0] d2;
  logic            hit;
  logic signed [COORD_W-1:0] rx, ry;

  logic pend_v_q, pend_v_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;
  logic signed [COORD_W-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;

  out_item_t res_d;
  logic      res_valid_d;

  btrq_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_BEACONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rx      = ram_rdata[DW-1:COORD_W];
  assign ry      = ram_rdata[COORD_W-1:0];
  assign dx_d    = {rx[COORD_W-1], rx} - {cx_q[COORD_W-1], cx_q};
  assign dy_d    = {ry[COORD_W-1], ry} - {cy_q[COORD_W-1], cy_q};
  assign px_prod = dx_q * dx_q;
  assign py_prod = dy_q * dy_q;
  assign d2      = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign hit     = d2 < D2_W'(r2_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    gid_d       = gid_q;
    load_query  = 1'b0;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_wdata   = {cmd_i.point_x, cmd_i.point_y};
    ram_raddr   = scan_q[AW-1:0];
    issue       = 1'b0;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    pend_x_d    = pend_x_q;
    pend_y_d    = pend_y_q;
    res_valid_d = 1'b0;
    res_d       = '{beacon_x: '0, beacon_y: '0, beacon_id: '0,
                    status: ST_NOMATCH, last: 1'b1};

    // A new hit releases the previous one, which is then known not to be last.
    if (hit_v_q) begin
      if (pend_v_q) begin
        res_valid_d = 1'b1;
        res_d       = '{beacon_x: pend_x_q, beacon_y: pend_y_q,
                        beacon_id: ID_W'(pend_idx_q), status: ST_RETURNED, last: 1'b0};
      end
      pend_v_d   = 1'b1;
      pend_idx_d = hit_idx_q;
      pend_x_d   = hit_x_q;
      pend_y_d   = hit_y_q;
    end

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            K_ADD: begin
              res_valid_d = 1'b1;
              if (count_q >= MaxCount) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
                res_d   = '{beacon_x: cmd_i.point_x, beacon_y: cmd_i.point_y,
                            beacon_id: ID_W'(count_q), status: ST_ADDED, last: 1'b1};
              end
            end
            K_GET: begin
              if (CMP_W'(cmd_i.wanted_id) < CMP_W'(count_q)) begin
                ram_raddr = cmd_i.wanted_id[AW-1:0];
                gid_d     = cmd_i.wanted_id[AW-1:0];
                state_d   = BK_GET;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            K_QUERY: begin
              load_query = 1'b1;
              state_d    = BK_PREP;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      BK_GET: begin
        res_valid_d = 1'b1;
        res_d       = '{beacon_x: rx, beacon_y: ry, beacon_id: ID_W'(gid_q),
                        status: ST_RETURNED, last: 1'b1};
        state_d     = BK_IDLE;
      end
      BK_PREP: begin
        scan_d   = '0;
        pend_v_d = 1'b0;
        state_d  = BK_SCAN;
      end
      BK_SCAN: begin
        if (scan_q < count_q) begin
          issue  = 1'b1;
          scan_d = scan_q + 1'b1;
        end else begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        // Pipeline empty: the held hit is the last one, or nothing matched.
        if (!rd_v_q && !sub_v_q && !mul_v_q && !hit_v_q) begin
          res_valid_d = 1'b1;
          if (pend_v_q) begin
            res_d = '{beacon_x: pend_x_q, beacon_y: pend_y_q,
                      beacon_id: ID_W'(pend_idx_q), status: ST_RETURNED, last: 1'b1};
          end
          pend_v_d = 1'b0;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      rd_v_q      <= 1'b0;
      sub_v_q     <= 1'b0;
      mul_v_q     <= 1'b0;
      hit_v_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      rd_v_q      <= issue;
      sub_v_q     <= rd_v_q;
      mul_v_q     <= sub_v_q;
      hit_v_q     <= mul_v_q && hit;
      pend_v_q    <= pend_v_d;
      res_valid_o <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gid_q      <= gid_d;
    if (load_query) begin
      cx_q  <= cmd_i.point_x;
      cy_q  <= cmd_i.point_y;
      rad_q <= cmd_i.radius;
    end
    r2_q       <= rad_q * rad_q;
    rd_idx_q   <= scan_q[AW-1:0];
    sub_idx_q  <= rd_idx_q;
    sub_x_q    <= rx;
    sub_y_q    <= ry;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    mul_idx_q  <= sub_idx_q;
    mul_x_q    <= sub_x_q;
    mul_y_q    <= sub_y_q;
    sqx_q      <= px_prod[SQ_W-1:0];
    sqy_q      <= py_prod[SQ_W-1:0];
    hit_idx_q  <= mul_idx_q;
    hit_x_q    <= mul_x_q;
    hit_y_q    <= mul_y_q;
    pend_idx_q <= pend_idx_d;
    pend_x_q   <= pend_x_d;
    pend_y_q   <= pend_y_d;
    res_o      <= res_d;
  end

endmodule

`default_nettype wire

// ----- rtl/beacon_table_range_query.sv -----
// Top level of the beacon table with fixed-radius neighbor search.
// Depends on btrq_pkg, btrq_front, btrq_back (and btrq_ram below it).
`default_nettype none

// Usage
//   Command channel: drive item_i and raise start_i; the beat is taken at a
//   rising edge where start_i is high and busy_o is low. A two-entry queue
//   sits between the decoder and the table engine, so busy_o rises only
//   when two commands are waiting behind the one being executed.
//   Result channel: res_valid_o marks a result beat on res_o for exactly one
//   cycle; the receiver must take it, there is no back pressure.
//   With the engine idle, an add or an unused code answers through the queue and
//   the result register; a valid get also waits in BK_GET for the RAM read. A
//   range query reads one table entry per cycle through the single RAM read
//   port and a four-stage read, subtract, square, sum-and-compare pipeline:
//   it holds the engine in BK_PREP, BK_SCAN over entries below the count
//   (up to MAX_BEACONS) and BK_DRAIN. Hits come out in table order at most
//   one per cycle, each held back until the next hit or the end of the scan
//   tells whether it carries last. An empty query answers one no-match beat.
//   Reset clears the beacon count, the queue and all valid flags; the table
//   RAM itself is not cleared, since only entries below the count are read.
module beacon_table_range_query #(
  parameter int unsigned MAX_BEACONS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire btrq_pkg::in_item_t  item_i,
  output logic                     res_valid_o,
  output btrq_pkg::out_item_t      res_o
);
  import btrq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Decode and queue command beats.
  btrq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .pop_i       (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  // Execute commands against the table, one at a time.
  btrq_back #(
    .MAX_BEACONS (MAX_BEACONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (cmd_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ----- rtl/btrq_checker.sv -----
// Port-level checks for beacon_table_range_query, bound to the top level.
// Depends on btrq_pkg.
`default_nettype none

module btrq_checker #(
  parameter int unsigned MAX_BEACONS = 64
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                res_valid_o,
  input wire btrq_pkg::out_item_t res_o
);
  import btrq_pkg::*;

  // Add and full answers are always single beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == ST_ADDED || res_o.status == ST_FULL) |-> res_o.last)
    else $error("add answer without last");

  // A no-match beat carries zero fields and ends its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_NOMATCH |->
      res_o.last && res_o.beacon_x == '0 && res_o.beacon_y == '0 && res_o.beacon_id == '0)
    else $error("no-match beat with nonzero fields or without last");

  // Ids handed out or returned stay inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == ST_RETURNED || res_o.status == ST_ADDED) |->
      {1'b0, res_o.beacon_id} < CMP_W'(MAX_BEACONS))
    else $error("beacon id beyond table size");

  // The queue only fills up after a command beat was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && !busy_o))
    else $error("busy rose without an accepted beat");

endmodule

bind beacon_table_range_query btrq_checker #(
  .MAX_BEACONS (MAX_BEACONS)
) u_btrq_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for beacon_table_range_query: command beats in, result beats out.
// Depends on btrq_pkg for the beat types and operation/status codes, and on beacon_table_range_query as the DUT.

module tb_top;
  import btrq_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 430;
  // Worst case after the last command: a full-table scan plus pipeline, with margin.
  localparam int unsigned TAIL_CYCLES  = TABLE_DEPTH + 40;
  // Simulated-time limit for the whole run; it sits well above the slowest legal run.
  localparam longint      RUN_LIMIT_NS = 64'd4_000_000;
  localparam int unsigned SHOWN_ERRORS = 10;

  // The package names the three live codes; the fourth is a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int COORD_MIN = -524288;
  localparam int COORD_MAX = 524287;
  localparam int RAD_MAX   = 524287;

  // -------------------------------------------------------------------------
  // Scoreboard: mirror of the beacon table plus the queue of expected beats.
  // -------------------------------------------------------------------------
  class beacon_scoreboard;
    logic signed [COORD_W-1:0] beacon_xs[TABLE_DEPTH];
    logic signed [COORD_W-1:0] beacon_ys[TABLE_DEPTH];
    int unsigned               beacon_count;
    out_item_t                 expected_beats[$];
    int unsigned               mismatches;

    function new();
      beacon_count = 0;
      mismatches   = 0;
    endfunction

    function void push_beat(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic [ID_W-1:0] id, logic [1:0] status, logic last);
      out_item_t beat;
      beat.beacon_x  = x;
      beat.beacon_y  = y;
      beat.beacon_id = id;
      beat.status    = status;
      beat.last      = last;
      expected_beats.insert(expected_beats.size(), beat);
    endfunction

    // Work out every result beat that one accepted command causes.
    function void note_command(in_item_t cmd);
      longint      cx;
      longint      cy;
      longint      r2;
      longint      dx;
      longint      dy;
      int unsigned hits;
      case (cmd.operation)
        OP_ADD: begin
          if (beacon_count >= TABLE_DEPTH) begin
            push_beat('0, '0, '0, ST_FULL, 1'b1);
          end else begin
            beacon_xs[beacon_count] = cmd.point_x;
            beacon_ys[beacon_count] = cmd.point_y;
            push_beat(cmd.point_x, cmd.point_y, ID_W'(beacon_count), ST_ADDED, 1'b1);
            beacon_count++;
          end
        end
        OP_GET: begin
          if (cmd.wanted_id < beacon_count) begin
            push_beat(beacon_xs[cmd.wanted_id], beacon_ys[cmd.wanted_id], cmd.wanted_id,
                      ST_RETURNED, 1'b0);
            expected_beats[expected_beats.size()-1].last = 1'b1;
          end else begin
            push_beat('0, '0, '0, ST_NOMATCH, 1'b1);
          end
        end
        OP_QUERY: begin
          // Compare squared distance with squared radius; strictly inside only.
          cx   = longint'($signed(cmd.point_x));
          cy   = longint'($signed(cmd.point_y));
          r2   = longint'(cmd.radius) * longint'(cmd.radius);
          hits = 0;
          for (int unsigned i = 0; i < beacon_count; i++) begin
            dx = longint'($signed(beacon_xs[i])) - cx;
            dy = longint'($signed(beacon_ys[i])) - cy;
            if (dx * dx + dy * dy < r2) begin
              push_beat(beacon_xs[i], beacon_ys[i], ID_W'(i), ST_RETURNED, 1'b0);
              hits++;
            end
          end
          if (hits == 0) begin
            push_beat('0, '0, '0, ST_NOMATCH, 1'b1);
          end else begin
            expected_beats[expected_beats.size()-1].last = 1'b1;
          end
        end
        default: begin
          push_beat('0, '0, '0, ST_NOMATCH, 1'b1);
        end
      endcase
    endfunction

    function string show(out_item_t b);
      return $sformatf("x=%0d y=%0d id=%0d status=%0d last=%0d",
                       $signed(b.beacon_x), $signed(b.beacon_y), b.beacon_id, b.status, b.last);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    // Compare one result beat, field by field, with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t exp_beat;
      if (expected_beats.size() == 0) begin
        report({"result with nothing expected: ", show(got)});
        return;
      end
      exp_beat = expected_beats.pop_front();
      if (got.beacon_x !== exp_beat.beacon_x || got.beacon_y !== exp_beat.beacon_y ||
          got.beacon_id !== exp_beat.beacon_id || got.status !== exp_beat.status ||
          got.last !== exp_beat.last) begin
        report({"expected ", show(exp_beat), " got ", show(got)});
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and the block
  // -------------------------------------------------------------------------
  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  in_item_t  item_i;
  logic      res_valid_o;
  out_item_t res_o;

  beacon_scoreboard          sb;
  logic signed [COORD_W-1:0] cluster_x[4];
  logic signed [COORD_W-1:0] cluster_y[4];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  beacon_table_range_query #(
    .MAX_BEACONS(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Results cannot be held off: take every strobed beat at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Driving tasks
  // -------------------------------------------------------------------------

  // Present one command and hold it until the block takes the beat; record it then.
  // Leave start_i high so back-to-back beats need no gap.
  task automatic send_beat(input in_item_t cmd);
    start_i <= 1'b1;
    item_i  <= cmd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_command(cmd);
  endtask

  // Drop start and put garbage on the command bus for the idle gap that n sets.
  task automatic idle_cycles(input int unsigned n);
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    start_i <= 1'b0;
    item_i  <= in_item_t'(raw[$bits(in_item_t)-1:0]);
    repeat (n) @(posedge clk_i);
  endtask

  // Drop start and hold off until every expected beat has come back.
  // Advance to the next edge first so the last noted command is in the queue.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t make_command(logic [1:0] op, int x, int y, int r, int id);
    in_item_t c;
    c.operation = op;
    c.point_x   = COORD_W'(x);
    c.point_y   = COORD_W'(y);
    c.radius    = RAD_W'(r);
    c.wanted_id = ID_W'(id);
    return c;
  endfunction

  // Mostly well-formed traffic: adds cluster so queries find neighbors, gets mostly
  // ask for live ids, queries mostly sit near a stored beacon. Unused fields stay random.
  function automatic in_item_t random_command();
    in_item_t    c;
    logic [95:0] raw;
    int unsigned pick;
    int unsigned k;
    raw  = {$urandom(), $urandom(), $urandom()};
    c    = in_item_t'(raw[$bits(in_item_t)-1:0]);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      c.operation = OP_ADD;
      if ($urandom_range(0, 2) != 0) begin
        k         = $urandom_range(0, 3);
        c.point_x = cluster_x[k] + COORD_W'($urandom_range(0, 8191)) - COORD_W'(4096);
        c.point_y = cluster_y[k] + COORD_W'($urandom_range(0, 8191)) - COORD_W'(4096);
      end
    end else if (pick < 38) begin
      c.operation = OP_GET;
      if (sb.beacon_count > 0 && $urandom_range(0, 4) != 0)
        c.wanted_id = ID_W'($urandom_range(0, sb.beacon_count - 1));
    end else if (pick < 95) begin
      c.operation = OP_QUERY;
      if (sb.beacon_count > 0 && $urandom_range(0, 9) < 7) begin
        k         = $urandom_range(0, sb.beacon_count - 1);
        c.point_x = sb.beacon_xs[k] + COORD_W'($urandom_range(0, 4095)) - COORD_W'(2048);
        c.point_y = sb.beacon_ys[k] + COORD_W'($urandom_range(0, 4095)) - COORD_W'(2048);
      end
      case ($urandom_range(0, 9))
        0:             c.radius = '0;
        1:             c.radius = '1;
        2, 3, 4, 5, 6: c.radius = RAD_W'($urandom_range(0, 8191));
        default:       ;  // keep the full-range random radius
      endcase
    end else begin
      c.operation = OP_UNUSED;
    end
    return c;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    in_item_t    directed[$];
    int unsigned sent;
    int unsigned burst;

    sb = new();
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    item_i  <= '0;
    for (int k = 0; k < 4; k++) begin
      cluster_x[k] = COORD_W'($urandom());
      cluster_y[k] = COORD_W'($urandom());
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-table answers, corner coordinates, unknown ids,
    // zero radius, a beacon sitting exactly on the radius, and the no-op code.
    directed.insert(directed.size(), make_command(OP_GET,    0, 0, 0, 0));
    directed.insert(directed.size(), make_command(OP_QUERY,  0, 0, RAD_MAX, 0));
    directed.insert(directed.size(), make_command(OP_UNUSED, -1, -1, RAD_MAX, 63));
    directed.insert(directed.size(), make_command(OP_ADD,    COORD_MIN, COORD_MIN, 0, 0));
    directed.insert(directed.size(), make_command(OP_ADD,    COORD_MAX, COORD_MAX, RAD_MAX, 63));
    directed.insert(directed.size(), make_command(OP_ADD,    0, 0, 0, 0));
    directed.insert(directed.size(), make_command(OP_ADD,    768, 1024, 0, 0));
    directed.insert(directed.size(), make_command(OP_GET,    0, 0, 0, 0));
    directed.insert(directed.size(), make_command(OP_GET,    0, 0, 0, 1));
    directed.insert(directed.size(), make_command(OP_GET,    0, 0, 0, 3));
    directed.insert(directed.size(), make_command(OP_GET,    0, 0, 0, 4));
    directed.insert(directed.size(), make_command(OP_GET,    0, 0, 0, 63));
    directed.insert(directed.size(), make_command(OP_QUERY,  0, 0, 0, 0));
    // (768,1024) lies exactly 1280 away: excluded at 1280, included at 1281.
    directed.insert(directed.size(), make_command(OP_QUERY,  0, 0, 1280, 0));
    directed.insert(directed.size(), make_command(OP_QUERY,  0, 0, 1281, 0));
    directed.insert(directed.size(), make_command(OP_QUERY,  COORD_MIN, COORD_MIN, RAD_MAX, 0));
    directed.insert(directed.size(), make_command(OP_QUERY,  COORD_MAX, COORD_MAX, RAD_MAX, 0));
    directed.insert(directed.size(), make_command(OP_QUERY,  0, 0, RAD_MAX, 0));
    directed.insert(directed.size(), make_command(OP_QUERY,  300000, -300000, 1, 0));
    directed.insert(directed.size(), make_command(OP_UNUSED, 0, 0, 0, 0));
    foreach (directed[i]) send_beat(directed[i]);
    drain_results();

    // Random part: bursts of random length; gaps of random length, sometimes none,
    // and now and then a full drain so the engine starts from idle again.
    // The adds fill the table part way through, so later adds hit the full case.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        send_beat(random_command());
        sent++;
        burst--;
      end
      case ($urandom_range(0, 9))
        0:       drain_results();
        1, 2, 3: ;  // run straight into the next burst
        default: idle_cycles($urandom_range(1, 20));
      endcase
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
